### design/bfc_pkg.sv
// ----------------------------------------------------------------------------
// bfc_pkg
// Types and constants shared by the packed bit-field counter store.
// ----------------------------------------------------------------------------
package bfc_pkg;

	localparam int MEM_BYTES_DEF = 4096;
	localparam int BYTE_BITS     = 8;
	localparam int WORD_BITS     = 64;
	localparam int POS_W         = 25;

	localparam logic [6:0] WIDTH_LIMIT = 7'd64;
	localparam logic [6:0] FW_RESET    = 7'd8;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_TOO_WIDE = 2'd1;
	localparam logic [1:0] STATUS_RANGE    = 2'd2;

	typedef struct packed {
		logic        opcode;
		logic [14:0] field_index;
		logic [63:0] write_value;
	} req_t;

	typedef struct packed {
		logic [63:0] read_value;
		logic [1:0]  status;
	} rsp_t;

	typedef struct packed {
		logic en;
		logic we;
	} mem_ctl_t;

	typedef enum logic [2:0] {
		SEQ_CLEAR,
		SEQ_IDLE,
		SEQ_CALC,
		SEQ_RD0,
		SEQ_RD1,
		SEQ_WR0,
		SEQ_WR1,
		SEQ_DONE
	} seq_state_t;

endpackage

### design/packed_bitfield_counter_store.sv
// ----------------------------------------------------------------------------
// packed_bitfield_counter_store
// Byte store of packed counter fields with a field-width register.
// ----------------------------------------------------------------------------
//  Channel   Signals                            Carries
//  req       req_valid, req_stall, req          opcode, field_index, write_value
//  rsp       rsp_valid, rsp_stall, rsp          read_value, status
//  config    psel, penable, pwrite, paddr, ...  field_width at byte address 0
//
// A transaction steps from acceptance to the result register through CALC for
// the bounds check, RD0 and RD1 to read the one or two 64-bit words under the
// field from the single-port memory, WR0 and WR1 to write them back on a write,
// and DONE to load the result. Checks that fail skip the memory. A new
// transaction is accepted only when the sequencer is back in idle after DONE.
// After reset the memory is cleared one word per cycle while req_stall stays
// high. A stalled result holds the sequencer in its last step until it is
// taken.
module packed_bitfield_counter_store #(
	parameter int MEM_BYTES = bfc_pkg::MEM_BYTES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	input  logic          req_valid,
	output logic          req_stall,
	input  bfc_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output bfc_pkg::rsp_t rsp
);

	localparam int   WORDS           = (MEM_BYTES + 7) / 8;
	localparam int   AW              = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam logic REG_FIELD_WIDTH = 1'b0;

	logic [6:0]                    field_width_q;
	bfc_pkg::mem_ctl_t             mem_ctl;
	logic [AW-1:0]                 mem_addr;
	logic [bfc_pkg::WORD_BITS-1:0] mem_wdata;
	logic [bfc_pkg::WORD_BITS-1:0] mem_rdata;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_width_q <= bfc_pkg::FW_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_FIELD_WIDTH) begin
			field_width_q <= pwdata[6:0];
		end
	end

	assign prdata = (paddr[2] == REG_FIELD_WIDTH) ? {25'd0, field_width_q} : 32'd0;

	bfc_seq #(
		.MEM_BYTES (MEM_BYTES),
		.WORDS     (WORDS),
		.AW        (AW)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.field_width (field_width_q),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp         (rsp),
		.mem_ctl     (mem_ctl),
		.mem_addr    (mem_addr),
		.mem_wdata   (mem_wdata),
		.mem_rdata   (mem_rdata)
	);

	bfc_mem #(
		.WORDS (WORDS),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.ctl   (mem_ctl),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

endmodule

### design/bfc_mem.sv
// ----------------------------------------------------------------------------
// bfc_mem
// Single-port word memory with registered read data.
// ----------------------------------------------------------------------------
module bfc_mem #(
	parameter int WORDS = bfc_pkg::MEM_BYTES_DEF / bfc_pkg::BYTE_BITS,
	parameter int AW    = 9
) (
	input  logic                             clk,
	input  bfc_pkg::mem_ctl_t                ctl,
	input  logic [AW-1:0]                    addr,
	input  logic [bfc_pkg::WORD_BITS-1:0]    wdata,
	output logic [bfc_pkg::WORD_BITS-1:0]    rdata
);

	logic [bfc_pkg::WORD_BITS-1:0] mem [WORDS];
	logic [bfc_pkg::WORD_BITS-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			if (ctl.we) begin
				mem[addr] <= wdata;
			end else begin
				rdata_q <= mem[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

### design/bfc_seq.sv
// ----------------------------------------------------------------------------
// bfc_seq
// Access sequencer: bounds and width checks, one- or two-word read, merge and
// write-back of one packed field, and the clearing sweep after reset.
// ----------------------------------------------------------------------------
module bfc_seq #(
	parameter int MEM_BYTES = bfc_pkg::MEM_BYTES_DEF,
	parameter int WORDS     = (MEM_BYTES + 7) / 8,
	parameter int AW        = (WORDS > 1) ? $clog2(WORDS) : 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [6:0]                       field_width,
	input  logic                             req_valid,
	output logic                             req_stall,
	input  bfc_pkg::req_t                    req,
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output bfc_pkg::rsp_t                    rsp,
	output bfc_pkg::mem_ctl_t                mem_ctl,
	output logic [AW-1:0]                    mem_addr,
	output logic [bfc_pkg::WORD_BITS-1:0]    mem_wdata,
	input  logic [bfc_pkg::WORD_BITS-1:0]    mem_rdata
);

	localparam int TOTAL_BITS = MEM_BYTES * bfc_pkg::BYTE_BITS;
	localparam int PW         = bfc_pkg::POS_W;

	bfc_pkg::seq_state_t state_q, state_d;

	logic [AW-1:0]  clr_cnt_q;
	bfc_pkg::req_t  req_q;
	logic [6:0]     w_q;
	logic [5:0]     off_q;
	logic [AW-1:0]  word_a_q;
	logic           span_q;
	logic [1:0]     status_q;
	logic [127:0]   mask_q;
	logic [127:0]   data_q;
	logic [127:0]   win_q;
	logic [63:0]    rval_q;
	logic           rsp_valid_q;
	bfc_pkg::rsp_t  rsp_q;

	logic [6:0]     w_eff;
	logic [PW-1:0]  start_c;
	logic [PW-1:0]  end_c;
	logic           range_c;
	logic           too_wide_c;
	logic [1:0]     status_c;
	logic [AW-1:0]  word_c;
	logic [6:0]     span_sum_c;
	logic [63:0]    top_ones_c;
	logic [63:0]    val_top_c;
	logic [127:0]   new_win_c;
	logic [127:0]   win_shift_c;
	logic           accept;
	logic           rsp_free;
	logic           write_ok;

	assign w_eff      = (field_width > bfc_pkg::WIDTH_LIMIT) ? bfc_pkg::WIDTH_LIMIT : field_width;
	assign start_c    = PW'(req_q.field_index) * PW'(w_eff);
	assign end_c      = start_c + PW'(w_eff);
	assign range_c    = end_c > PW'(TOTAL_BITS);
	assign too_wide_c = (w_eff < bfc_pkg::WIDTH_LIMIT) ? ((req_q.write_value >> w_eff) != 64'd0)
		: 1'b0;
	assign word_c     = start_c[6 +: AW];
	assign span_sum_c = {1'b0, start_c[5:0]} + w_eff;

	always_comb begin
		status_c = bfc_pkg::STATUS_OK;
		if (range_c) begin
			status_c = bfc_pkg::STATUS_RANGE;
		end else if (req_q.opcode == bfc_pkg::OP_WRITE && too_wide_c) begin
			status_c = bfc_pkg::STATUS_TOO_WIDE;
		end
	end

	assign top_ones_c  = ~({64{1'b1}} >> w_q);
	assign val_top_c   = req_q.write_value << (7'd64 - w_q);
	assign new_win_c   = (win_q & ~mask_q) | data_q;
	assign win_shift_c = win_q << off_q;

	assign accept   = req_valid && (state_q == bfc_pkg::SEQ_IDLE);
	assign rsp_free = !rsp_valid_q || !rsp_stall;
	assign write_ok = (req_q.opcode == bfc_pkg::OP_WRITE) && (status_q == bfc_pkg::STATUS_OK);

	always_comb begin
		state_d = state_q;
		case (state_q)
			bfc_pkg::SEQ_CLEAR: begin
				if (clr_cnt_q == AW'(WORDS - 1)) state_d = bfc_pkg::SEQ_IDLE;
			end
			bfc_pkg::SEQ_IDLE: begin
				if (req_valid) state_d = bfc_pkg::SEQ_CALC;
			end
			bfc_pkg::SEQ_CALC: begin
				if (status_c != bfc_pkg::STATUS_OK) begin
					state_d = bfc_pkg::SEQ_DONE;
				end else begin
					state_d = bfc_pkg::SEQ_RD0;
				end
			end
			bfc_pkg::SEQ_RD0: state_d = bfc_pkg::SEQ_RD1;
			bfc_pkg::SEQ_RD1: state_d = bfc_pkg::SEQ_WR0;
			bfc_pkg::SEQ_WR0: state_d = bfc_pkg::SEQ_WR1;
			bfc_pkg::SEQ_WR1: state_d = bfc_pkg::SEQ_DONE;
			bfc_pkg::SEQ_DONE: begin
				if (rsp_free) state_d = bfc_pkg::SEQ_IDLE;
			end
			default: state_d = bfc_pkg::SEQ_IDLE;
		endcase
	end

	always_comb begin
		req_stall  = (state_q != bfc_pkg::SEQ_IDLE);
		mem_ctl.en = 1'b0;
		mem_ctl.we = 1'b0;
		mem_addr   = word_a_q;
		mem_wdata  = new_win_c[127:64];
		case (state_q)
			bfc_pkg::SEQ_CLEAR: begin
				mem_ctl.en = 1'b1;
				mem_ctl.we = 1'b1;
				mem_addr   = clr_cnt_q;
				mem_wdata  = '0;
			end
			bfc_pkg::SEQ_CALC: begin
				mem_ctl.en = (status_c == bfc_pkg::STATUS_OK);
				mem_addr   = word_c;
			end
			bfc_pkg::SEQ_RD0: begin
				mem_ctl.en = span_q;
				mem_addr   = word_a_q + AW'(1);
			end
			bfc_pkg::SEQ_WR0: begin
				mem_ctl.en = write_ok;
				mem_ctl.we = write_ok;
			end
			bfc_pkg::SEQ_WR1: begin
				mem_ctl.en = write_ok && span_q;
				mem_ctl.we = write_ok && span_q;
				mem_addr   = word_a_q + AW'(1);
				mem_wdata  = new_win_c[63:0];
			end
			default: begin
				mem_ctl.en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bfc_pkg::SEQ_CLEAR;
			clr_cnt_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == bfc_pkg::SEQ_CLEAR) clr_cnt_q <= clr_cnt_q + AW'(1);
			if (state_q == bfc_pkg::SEQ_DONE && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) req_q <= req;
		if (state_q == bfc_pkg::SEQ_CALC) begin
			w_q      <= w_eff;
			off_q    <= start_c[5:0];
			word_a_q <= word_c;
			span_q   <= span_sum_c > bfc_pkg::WIDTH_LIMIT;
			status_q <= status_c;
		end
		if (state_q == bfc_pkg::SEQ_RD0) begin
			mask_q          <= {top_ones_c, 64'd0} >> off_q;
			data_q          <= ({val_top_c, 64'd0} >> off_q) & ({top_ones_c, 64'd0} >> off_q);
			win_q[127:64]   <= mem_rdata;
		end
		if (state_q == bfc_pkg::SEQ_RD1) begin
			win_q[63:0] <= span_q ? mem_rdata : 64'd0;
		end
		if (state_q == bfc_pkg::SEQ_WR0) begin
			rval_q <= win_shift_c[127:64] >> (7'd64 - w_q);
		end
		if (state_q == bfc_pkg::SEQ_DONE && rsp_free) begin
			rsp_q.status     <= status_q;
			rsp_q.read_value <= (req_q.opcode == bfc_pkg::OP_READ &&
				status_q == bfc_pkg::STATUS_OK) ? rval_q : 64'd0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_we_states: assert property (@(posedge clk) disable iff (!arst_n)
		mem_ctl.we |-> (state_q == bfc_pkg::SEQ_CLEAR || state_q == bfc_pkg::SEQ_WR0 ||
			state_q == bfc_pkg::SEQ_WR1))
		else $error("memory written outside a write or clear step");

	a_we_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_ctl.we && state_q != bfc_pkg::SEQ_CLEAR) |->
			(req_q.opcode == bfc_pkg::OP_WRITE && status_q == bfc_pkg::STATUS_OK))
		else $error("memory written for a read or a failed write");

	a_accept_calc: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> state_q == bfc_pkg::SEQ_CALC)
		else $error("accepted transaction did not start the sequence");

	a_second_word: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bfc_pkg::SEQ_WR1 && mem_ctl.we) |-> span_q)
		else $error("second word written for a field inside one word");

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the packed bit-field counter store. A table of
// directed accesses covers the store's ends, fields past the end, values too
// wide for the field and the odd field widths. Random reads and writes then
// follow under several field widths and handshake idling patterns. Each
// result is checked against the table's result or a bit-level shadow of the store.
// ----------------------------------------------------------------------------
module testbench;

	localparam int STORE_BITS  = bfc_pkg::MEM_BYTES_DEF * bfc_pkg::BYTE_BITS;
	localparam int MAX_INDEX   = 32767;
	localparam int DRAIN_LIMIT = 20000;
	localparam int SETTLE      = 12;
	localparam int CHUNKS      = 12;
	localparam int CHUNK_ITEMS = 75;

	localparam logic [2:0] FW_ADDR    = 3'd0;
	localparam logic [2:0] SPARE_ADDR = 3'd4;

	typedef enum logic [1:0] {
		ROW_CFG,
		ROW_PRED,
		ROW_FIXED
	} row_kind_t;

	typedef struct packed {
		row_kind_t     kind;
		logic [2:0]    addr;
		logic [31:0]   data;
		bfc_pkg::req_t item;
		bfc_pkg::rsp_t rsp;
	} dir_row_t;

	typedef struct packed {
		bfc_pkg::req_t item;
		logic          has_typed;
		bfc_pkg::rsp_t typed_rsp;
	} stim_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          psel = 1'b0;
	logic          penable = 1'b0;
	logic          pwrite = 1'b0;
	logic [2:0]    paddr = '0;
	logic [31:0]   pwdata = '0;
	logic [31:0]   prdata;
	logic          pready;
	logic          req_valid = 1'b0;
	logic          req_stall;
	bfc_pkg::req_t req = '0;
	logic          rsp_valid;
	logic          rsp_stall = 1'b0;
	bfc_pkg::rsp_t rsp;

	bit            shadow_bits [0:STORE_BITS-1];
	logic [6:0]    fw_shadow = bfc_pkg::FW_RESET;
	stim_t         req_queue [$];
	bfc_pkg::rsp_t pending_rsp [$];
	dir_row_t      directed [$];
	stim_t         active_stim;
	bfc_pkg::rsp_t predicted;
	bfc_pkg::rsp_t want;
	bit            take_next;
	int            sender_pct = 0;
	int            stall_pct = 0;
	int            fails = 0;

	packed_bitfield_counter_store dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #5 clk = ~clk;

	function automatic bfc_pkg::rsp_t predict_access(bfc_pkg::req_t r);
		int unsigned w;
		int unsigned start;
		int unsigned k;
		bfc_pkg::rsp_t o;
		w = (fw_shadow > bfc_pkg::WIDTH_LIMIT) ? bfc_pkg::WIDTH_LIMIT : fw_shadow;
		start = r.field_index * w;
		o.read_value = '0;
		o.status = bfc_pkg::STATUS_OK;
		if (start + w > STORE_BITS) begin
			o.status = bfc_pkg::STATUS_RANGE;
		end else if (r.opcode == bfc_pkg::OP_READ) begin
			for (k = 0; k < w; k++)
				o.read_value = {o.read_value[62:0], shadow_bits[start + k]};
		end else if (w < bfc_pkg::WORD_BITS && (r.write_value >> w) != 64'd0) begin
			o.status = bfc_pkg::STATUS_TOO_WIDE;
		end else begin
			for (k = 0; k < w; k++)
				shadow_bits[start + k] = r.write_value[w - 1 - k];
		end
		return o;
	endfunction

	function automatic dir_row_t cfg_row(logic [2:0] a, logic [31:0] d);
		dir_row_t row;
		row = '0;
		row.kind = ROW_CFG;
		row.addr = a;
		row.data = d;
		return row;
	endfunction

	function automatic dir_row_t pred_row(logic op, logic [14:0] idx, logic [63:0] v);
		dir_row_t row;
		row = '0;
		row.kind = ROW_PRED;
		row.item.opcode = op;
		row.item.field_index = idx;
		row.item.write_value = v;
		return row;
	endfunction

	function automatic dir_row_t fixed_row(logic op, logic [14:0] idx, logic [63:0] v,
			logic [63:0] rd, logic [1:0] st);
		dir_row_t row;
		row = pred_row(op, idx, v);
		row.kind = ROW_FIXED;
		row.rsp.read_value = rd;
		row.rsp.status = st;
		return row;
	endfunction

	// Request side: predict on acceptance, then present the next transaction or idle.
	always @(posedge clk) begin
		if (arst_n) begin
			take_next = !req_valid;
			if (req_valid && !req_stall) begin
				predicted = predict_access(active_stim.item);
				pending_rsp.push_back(active_stim.has_typed ? active_stim.typed_rsp : predicted);
				take_next = 1'b1;
			end
			if (take_next) begin
				if (req_queue.size() > 0 && $urandom_range(0, 99) >= sender_pct) begin
					active_stim = req_queue.pop_front();
					req <= active_stim.item;
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (pending_rsp.size() == 0) begin
					$error("result with no transaction outstanding: read_value %h status %0d",
						rsp.read_value, rsp.status);
					fails++;
				end else begin
					want = pending_rsp.pop_front();
					if (rsp.read_value !== want.read_value) begin
						$error("read_value: expected %h, got %h", want.read_value, rsp.read_value);
						fails++;
					end
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						fails++;
					end
				end
			end
			rsp_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	task automatic wait_idle();
		int cycles;
		cycles = 0;
		while ((req_queue.size() != 0 || req_valid || pending_rsp.size() != 0)
				&& cycles < DRAIN_LIMIT) begin
			@(negedge clk);
			cycles++;
		end
		if (req_queue.size() != 0 || req_valid || pending_rsp.size() != 0) begin
			$error("%0d results still outstanding", pending_rsp.size());
			fails++;
		end
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic program_reg(logic [2:0] addr, logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (addr == FW_ADDR)
			fw_shadow = data[6:0];
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == FW_ADDR) begin
			@(posedge clk);
			penable <= 1'b1;
			@(posedge clk);
			while (!pready) @(posedge clk);
			if (prdata[6:0] !== fw_shadow) begin
				$error("field_width: expected %0d, got %0d", fw_shadow, prdata[6:0]);
				fails++;
			end
			penable <= 1'b0;
		end
		psel <= 1'b0;
	endtask

	initial begin
		stim_t s;
		int chunk;
		int n;
		int w;
		int eff;
		int max_idx;
		int idx;
		int sel;
		logic [63:0] mask;
		logic [63:0] v;

		for (int i = 0; i < STORE_BITS; i++)
			shadow_bits[i] = 1'b0;

		directed.push_back(fixed_row(bfc_pkg::OP_READ, 15'd0, 64'd0, 64'd0, bfc_pkg::STATUS_OK));
		directed.push_back(fixed_row(bfc_pkg::OP_READ, 15'd4095, 64'd0, 64'd0,
			bfc_pkg::STATUS_OK));
		directed.push_back(fixed_row(bfc_pkg::OP_READ, 15'd4096, 64'd0, 64'd0,
			bfc_pkg::STATUS_RANGE));
		directed.push_back(fixed_row(bfc_pkg::OP_READ, 15'd32767, 64'd0, 64'd0,
			bfc_pkg::STATUS_RANGE));
		directed.push_back(fixed_row(bfc_pkg::OP_WRITE, 15'd4095, 64'hFF, 64'd0,
			bfc_pkg::STATUS_OK));
		directed.push_back(fixed_row(bfc_pkg::OP_WRITE, 15'd0, 64'h100, 64'd0,
			bfc_pkg::STATUS_TOO_WIDE));
		directed.push_back(fixed_row(bfc_pkg::OP_WRITE, 15'd4096, 64'h100, 64'd0,
			bfc_pkg::STATUS_RANGE));
		directed.push_back(fixed_row(bfc_pkg::OP_READ, 15'd4095, 64'd0, 64'hFF,
			bfc_pkg::STATUS_OK));
		directed.push_back(pred_row(bfc_pkg::OP_WRITE, 15'd0, 64'hA5));
		directed.push_back(pred_row(bfc_pkg::OP_READ, 15'd0, 64'hFFFF_FFFF_FFFF_FFFF));
		directed.push_back(cfg_row(FW_ADDR, 32'd1));
		directed.push_back(fixed_row(bfc_pkg::OP_WRITE, 15'd32767, 64'd1, 64'd0,
			bfc_pkg::STATUS_OK));
		directed.push_back(fixed_row(bfc_pkg::OP_WRITE, 15'd32767, 64'd2, 64'd0,
			bfc_pkg::STATUS_TOO_WIDE));
		directed.push_back(pred_row(bfc_pkg::OP_READ, 15'd32767, 64'd0));
		directed.push_back(cfg_row(FW_ADDR, 32'd64));
		directed.push_back(fixed_row(bfc_pkg::OP_WRITE, 15'd511, 64'hFFFF_FFFF_FFFF_FFFF,
			64'd0, bfc_pkg::STATUS_OK));
		directed.push_back(fixed_row(bfc_pkg::OP_READ, 15'd511, 64'd0,
			64'hFFFF_FFFF_FFFF_FFFF, bfc_pkg::STATUS_OK));
		directed.push_back(fixed_row(bfc_pkg::OP_READ, 15'd512, 64'd0, 64'd0,
			bfc_pkg::STATUS_RANGE));
		directed.push_back(pred_row(bfc_pkg::OP_WRITE, 15'd0, 64'h0123_4567_89AB_CDEF));
		directed.push_back(cfg_row(FW_ADDR, 32'd0));
		directed.push_back(fixed_row(bfc_pkg::OP_READ, 15'd32767, 64'd0, 64'd0,
			bfc_pkg::STATUS_OK));
		directed.push_back(fixed_row(bfc_pkg::OP_WRITE, 15'd5, 64'd0, 64'd0,
			bfc_pkg::STATUS_OK));
		directed.push_back(fixed_row(bfc_pkg::OP_WRITE, 15'd5, 64'd1, 64'd0,
			bfc_pkg::STATUS_TOO_WIDE));
		directed.push_back(cfg_row(FW_ADDR, 32'd127));
		directed.push_back(fixed_row(bfc_pkg::OP_READ, 15'd0, 64'd0,
			64'h0123_4567_89AB_CDEF, bfc_pkg::STATUS_OK));
		directed.push_back(fixed_row(bfc_pkg::OP_READ, 15'd512, 64'd0, 64'd0,
			bfc_pkg::STATUS_RANGE));
		directed.push_back(cfg_row(FW_ADDR, 32'd13));
		directed.push_back(pred_row(bfc_pkg::OP_WRITE, 15'd100, 64'h1FFF));
		directed.push_back(fixed_row(bfc_pkg::OP_WRITE, 15'd100, 64'h2000, 64'd0,
			bfc_pkg::STATUS_TOO_WIDE));
		directed.push_back(fixed_row(bfc_pkg::OP_READ, 15'd2520, 64'd0, 64'd0,
			bfc_pkg::STATUS_RANGE));
		directed.push_back(pred_row(bfc_pkg::OP_READ, 15'd2519, 64'd0));
		directed.push_back(cfg_row(SPARE_ADDR, 32'd1));
		directed.push_back(pred_row(bfc_pkg::OP_READ, 15'd100, 64'd0));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed[i]) begin
			if (directed[i].kind == ROW_CFG) begin
				wait_idle();
				program_reg(directed[i].addr, directed[i].data);
			end else begin
				s.item = directed[i].item;
				s.has_typed = (directed[i].kind == ROW_FIXED);
				s.typed_rsp = directed[i].rsp;
				req_queue.push_back(s);
			end
		end

		for (chunk = 0; chunk < CHUNKS; chunk++) begin
			wait_idle();
			case (chunk % 4)
				0: begin
					sender_pct = 0;
					stall_pct = 0;
				end
				1: begin
					sender_pct = 80;
					stall_pct = 0;
				end
				2: begin
					sender_pct = 0;
					stall_pct = 80;
				end
				default: begin
					sender_pct = 8;
					stall_pct = 8;
				end
			endcase
			case ($urandom_range(0, 5))
				0: w = $urandom_range(1, 8);
				1: w = $urandom_range(9, 64);
				2: w = 64;
				3: w = 1;
				4: w = $urandom_range(65, 127);
				default: w = $urandom_range(0, 3);
			endcase
			program_reg(FW_ADDR, ($urandom & ~32'h7F) | w);
			eff = (w > 64) ? 64 : w;
			max_idx = (eff == 0) ? MAX_INDEX : STORE_BITS / eff - 1;
			mask = (eff >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << eff) - 64'd1);
			for (n = 0; n < CHUNK_ITEMS; n++) begin
				sel = $urandom_range(0, 99);
				if (sel < 50)
					idx = $urandom_range(0, (max_idx < 63) ? max_idx : 63);
				else if (sel < 75)
					idx = $urandom_range(0, max_idx);
				else if (sel < 90)
					idx = max_idx - 1 + $urandom_range(0, 3);
				else
					idx = $urandom_range(0, MAX_INDEX);
				if (idx > MAX_INDEX)
					idx = MAX_INDEX;
				v = {$urandom, $urandom};
				sel = $urandom_range(0, 99);
				if (sel < 70)
					v = v & mask;
				else if (sel < 85 && eff < 64)
					v = (v & mask) | (64'd1 << eff);
				s.item.opcode = ($urandom_range(0, 99) < 45) ? bfc_pkg::OP_WRITE : bfc_pkg::OP_READ;
				s.item.field_index = idx[14:0];
				s.item.write_value = v;
				s.has_typed = 1'b0;
				s.typed_rsp = '0;
				req_queue.push_back(s);
			end
		end

		wait_idle();
		if (fails == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

### files.f
design/bfc_pkg.sv
design/bfc_mem.sv
design/bfc_seq.sv
design/packed_bitfield_counter_store.sv
tb/testbench.sv
